@@ hdl/wpf_pkg.sv @@
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared constants and status codes for the prime test and factorial residue.
// ----------------------------------------------------------------------------
package wpf_pkg;

  localparam int NUM_WIDTH_DEF = 16;

  localparam int STATUS_WIDTH = 2;

  localparam logic [STATUS_WIDTH-1:0] ST_REJECT    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_PRIME     = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_COMPOSITE = 2'd2;

  // smallest value that is tested at all
  localparam int MIN_TESTED = 4;

endpackage

@@ hdl/wilson_prime_factorial_mod_top.sv @@
// sequencing: n below 4 is rejected without arithmetic; each trial divisor and each
// factorial step runs through the shared bit-serial mod-multiply unit; a prime n
// tries every divisor up to sqrt(n) and then the factorial steps, a composite n
// stops at its smallest divisor
// throughput: one transaction at a time; input stalled until the result is staged
// reset: asynchronous active low, clears sequencer and output valid
// ----------------------------------------------------------------------------
// wilson_prime_factorial_mod_top
// Trial-division prime test followed by (n-1)! mod n for primes.
// ----------------------------------------------------------------------------
module wilson_prime_factorial_mod_top
  import wpf_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [NUM_WIDTH-1:0]    number_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STATUS_WIDTH-1:0] status_o,
  output logic [NUM_WIDTH-1:0]    residue_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TRIAL = 3'd1;
  localparam logic [2:0] S_TWAIT = 3'd2;
  localparam logic [2:0] S_FACT  = 3'd3;
  localparam logic [2:0] S_FWAIT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [NUM_WIDTH-1:0]    n_q, n_d;
  logic [NUM_WIDTH-1:0]    div_q, div_d;
  logic [NUM_WIDTH:0]      sq_q, sq_d;
  logic [NUM_WIDTH-1:0]    acc_q, acc_d;
  logic [NUM_WIDTH-1:0]    k_q, k_d;
  logic [STATUS_WIDTH-1:0] st_q, st_d;
  logic                    out_vld_q, out_vld_d;
  logic [STATUS_WIDTH-1:0] out_st_q, out_st_d;
  logic [NUM_WIDTH-1:0]    out_res_q, out_res_d;

  logic                    in_acc;
  logic                    mm_start;
  logic [NUM_WIDTH-1:0]    mm_a, mm_b, mm_m;
  logic                    mm_done;
  logic [NUM_WIDTH-1:0]    mm_res;
  logic                    trial_over;
  logic                    fact_over;
  logic                    out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign trial_over = (sq_q > {1'b0, n_q});
  assign fact_over  = (k_q <= NUM_WIDTH'(1));

  always_comb begin
    mm_start = 1'b0;
    if (state_q == S_TRIAL) begin
      mm_start = !trial_over;
    end else if (state_q == S_FACT) begin
      mm_start = !fact_over;
    end
  end

  // trial: 1 * n mod d; factorial: acc * k mod n
  assign mm_a = (state_q == S_FACT) ? acc_q : NUM_WIDTH'(1);
  assign mm_b = (state_q == S_FACT) ? k_q : n_q;
  assign mm_m = (state_q == S_FACT) ? n_q : div_q;

  wpf_modmul #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (mm_m),
    .done_o  (mm_done),
    .result_o(mm_res)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    div_d     = div_q;
    sq_d      = sq_q;
    acc_d     = acc_q;
    k_d       = k_q;
    st_d      = st_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_st_d  = out_st_q;
    out_res_d = out_res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          n_d   = number_i;
          div_d = NUM_WIDTH'(2);
          sq_d  = (NUM_WIDTH+1)'(MIN_TESTED);
          acc_d = '0;
          if (number_i < NUM_WIDTH'(MIN_TESTED)) begin
            st_d    = ST_REJECT;
            state_d = S_DONE;
          end else begin
            state_d = S_TRIAL;
          end
        end
      end
      S_TRIAL: begin
        if (trial_over) begin
          acc_d   = NUM_WIDTH'(1);
          k_d     = n_q - NUM_WIDTH'(1);
          state_d = S_FACT;
        end else begin
          state_d = S_TWAIT;
        end
      end
      S_TWAIT: begin
        if (mm_done) begin
          if (mm_res == '0) begin
            st_d    = ST_COMPOSITE;
            acc_d   = '0;
            state_d = S_DONE;
          end else begin
            sq_d    = sq_q + {div_q, 1'b1};
            div_d   = div_q + NUM_WIDTH'(1);
            state_d = S_TRIAL;
          end
        end
      end
      S_FACT: begin
        if (fact_over) begin
          st_d    = ST_PRIME;
          state_d = S_DONE;
        end else begin
          state_d = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (mm_done) begin
          acc_d   = mm_res;
          k_d     = k_q - NUM_WIDTH'(1);
          state_d = S_FACT;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_st_d  = st_q;
          out_res_d = acc_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    div_q     <= div_d;
    sq_q      <= sq_d;
    acc_q     <= acc_d;
    k_q       <= k_d;
    st_q      <= st_d;
    out_st_q  <= out_st_d;
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_st_q;
  assign residue_o   = out_res_q;

  // unit finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> (state_q == S_TWAIT || state_q == S_FWAIT))
    else $error("modmul done outside a wait state");

  // reduced value stays below its modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mm_done && state_q == S_FWAIT) |-> (mm_res < n_q))
    else $error("factorial residue not reduced");

  // only a prime carries a residue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_PRIME) |-> (residue_o == '0))
    else $error("residue on non-prime result");

  // accepted transaction blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after accept");

endmodule

@@ hdl/wpf_modmul.sv @@
// ----------------------------------------------------------------------------
// wpf_modmul
// Bit-serial modular multiplier: result = (a * b) mod m, one bit of b per
// cycle, msb first. Requires a < m and m >= 2.
// ----------------------------------------------------------------------------
module wpf_modmul
  import wpf_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] a_i,
  input  logic [NUM_WIDTH-1:0] b_i,
  input  logic [NUM_WIDTH-1:0] m_i,
  output logic                 done_o,
  output logic [NUM_WIDTH-1:0] result_o
);

  localparam int CntWidth = $clog2(NUM_WIDTH + 1);
  localparam int AccWidth = NUM_WIDTH + 2;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [NUM_WIDTH-1:0] a_q, a_d;
  logic [NUM_WIDTH-1:0] b_q, b_d;
  logic [NUM_WIDTH-1:0] m_q, m_d;
  logic [NUM_WIDTH-1:0] r_q, r_d;

  logic [AccWidth-1:0] m_ext;
  logic [AccWidth-1:0] dbl;
  logic [AccWidth-1:0] red1;
  logic [AccWidth-1:0] sum;
  logic [AccWidth-1:0] red2;

  always_comb begin
    m_ext = {2'b00, m_q};
    dbl   = {1'b0, r_q, 1'b0};
    red1  = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum   = red1 + (b_q[NUM_WIDTH-1] ? {2'b00, a_q} : '0);
    red2  = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    r_d    = r_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(NUM_WIDTH);
      a_d    = a_i;
      b_d    = b_i;
      m_d    = m_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d   = red2[NUM_WIDTH-1:0];
      b_d   = {b_q[NUM_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
    r_q <= r_d;
  end

  assign done_o   = done_q;
  assign result_o = r_q;

endmodule

@@ bench/wilson_residue_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wilson_residue_checker
// Watches the number and result channels of the prime test. Every accepted
// number is classified on the fly (rejected, prime with its (n-1)! mod n
// residue, or composite) and queued. Every accepted result is compared field
// by field with the oldest queued prediction. The mismatch count and the
// number of predictions still waiting are handed to the testbench top.
// ----------------------------------------------------------------------------
module wilson_residue_checker
  import wpf_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [NUM_WIDTH-1:0]    number_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [STATUS_WIDTH-1:0] status_i,
  input  logic [NUM_WIDTH-1:0]    residue_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  logic [STATUS_WIDTH-1:0] status_due_q[$];
  logic [NUM_WIDTH-1:0]    residue_due_q[$];
  int                      mismatches;

  // trial division, then the running factorial product for primes
  function automatic void wilson_verdict(input logic [NUM_WIDTH-1:0] n,
                                         output logic [STATUS_WIDTH-1:0] st,
                                         output logic [NUM_WIDTH-1:0] res);
    longint unsigned nv;
    longint unsigned d;
    longint unsigned acc;
    longint unsigned k;
    bit              divisible;
    nv = 64'(n);
    res = '0;
    divisible = 1'b0;
    if (nv < 64'(MIN_TESTED)) begin
      st = ST_REJECT;
      return;
    end
    for (d = 2; d * d <= nv; d++) begin
      if (nv % d == 0) begin
        divisible = 1'b1;
        break;
      end
    end
    if (divisible) begin
      st = ST_COMPOSITE;
      return;
    end
    acc = 1;
    for (k = nv - 1; k > 1; k--) begin
      acc = (acc * k) % nv;
    end
    st = ST_PRIME;
    res = acc[NUM_WIDTH-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [STATUS_WIDTH-1:0] st;
    logic [NUM_WIDTH-1:0]    res;
    logic [STATUS_WIDTH-1:0] st_due;
    logic [NUM_WIDTH-1:0]    res_due;
    if (!rst_ni) begin
      status_due_q.delete();
      residue_due_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        wilson_verdict(number_i, st, res);
        status_due_q.push_back(st);
        residue_due_q.push_back(res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (status_due_q.size() == 0) begin
          $error("unexpected result transaction: status %0d residue %0d",
                 status_i, residue_i);
          mismatches++;
        end else begin
          st_due = status_due_q.pop_front();
          res_due = residue_due_q.pop_front();
          if (status_i !== st_due) begin
            $error("status: expected %0d, actual %0d", st_due, status_i);
            mismatches++;
          end
          if (residue_i !== res_due) begin
            $error("residue: expected %0d, actual %0d", res_due, residue_i);
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_o <= status_due_q.size();
    end
  end

endmodule

@@ bench/tb_wilson_prime_factorial_mod_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wilson_prime_factorial_mod_top
// Drives numbers into the prime test and factorial residue block: a directed
// set of edge values, small values, prime squares and wide words, then random
// numbers kept mostly small so the slow prime path stays affordable. Both
// channels idle at random in the first two of three phases and not in the
// last; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_wilson_prime_factorial_mod_top;
  import wpf_pkg::*;

  localparam int NUM_WIDTH = NUM_WIDTH_DEF;
  localparam int RANDOM_NUMBERS = 75;
  localparam int DRAIN_CYCLES = 100;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_stall;
  logic [NUM_WIDTH-1:0]    number;
  logic                    out_valid;
  logic                    out_stall;
  logic [STATUS_WIDTH-1:0] status;
  logic [NUM_WIDTH-1:0]    residue;
  int                      mismatch_count;
  int                      pending;
  int                      send_idle_pct;
  int                      recv_stall_pct;

  wilson_prime_factorial_mod_top #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .number_i   (number),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .status_o   (status),
    .residue_o  (residue)
  );

  wilson_residue_checker #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .number_i        (number),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .residue_i       (residue),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic send_number(input logic [NUM_WIDTH-1:0] n);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    number <= n;
    do @(posedge clk_i); while (in_stall);
  endtask

  // hold the number channel until every result is back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [NUM_WIDTH-1:0] random_number();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 2) return NUM_WIDTH'($urandom_range(4, 65535)) & ~NUM_WIDTH'(1);
    if (sel == 2) return NUM_WIDTH'($urandom_range(4, 2047));
    if (sel == 3) return NUM_WIDTH'($urandom_range(0, 15));
    return NUM_WIDTH'($urandom_range(4, 400));
  endfunction

  initial begin
    logic [NUM_WIDTH-1:0] directed[$];
    directed = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 13, 25, 49, 97, 121, 169,
                 1021, 1024, 21845, 43690, 32768, 63001, 65533, 65534, 65535};
    rst_ni = 1'b0;
    in_valid = 1'b0;
    number = '0;
    send_idle_pct = 7;
    recv_stall_pct = 82;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send_number(directed[i]);
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i == RANDOM_NUMBERS / 3) begin
        hold_until_drained();
        send_idle_pct = 82;
        recv_stall_pct = 7;
      end else if (i == 2 * RANDOM_NUMBERS / 3) begin
        hold_until_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      send_number(random_number());
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(64'd200_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ wilson_prime_factorial_mod_top.f @@
hdl/wpf_pkg.sv
hdl/wpf_modmul.sv
hdl/wilson_prime_factorial_mod_top.sv
bench/wilson_residue_checker.sv
bench/tb_wilson_prime_factorial_mod_top.sv
